@@ rtl/smerm_pkg.sv @@
// Shared types and constants for the sliding minute event rate monitor.
package smerm_pkg;

  localparam int TICK_W     = 16;
  localparam int SUM_W      = 32;
  localparam int LOAD_W     = 7;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SUM_COUNT  = 5;
  localparam int SUM_IDX_W  = 3;

  localparam int DIV_REM_W  = 40;
  localparam int DIV_CNT_W  = 3;

  localparam logic [TICK_W-1:0] TICK_MAX  = '1;
  localparam logic [TICK_W-1:0] TPS_RESET = 16'd1000;
  localparam logic [LOAD_W-1:0] PCT_MAX   = 7'd100;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LAST = 3'd6;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_SYSCALL = 2'd1,
    OP_IRQ     = 2'd2,
    OP_LOCK    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS    = 2'd0,
    CFG_ENABLE = 2'd1
  } cfg_idx_t;

  typedef enum logic [SUM_IDX_W-1:0] {
    SUM_SYS  = 3'd0,
    SUM_IRQ  = 3'd1,
    SUM_LOCK = 3'd2,
    SUM_BUSY = 3'd3,
    SUM_IDLE = 3'd4
  } sum_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_ROT,
    S_DSTART,
    S_DIV,
    S_OUT
  } seq_state_t;

  // Handshake between sequencer and divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [LOAD_W-1:0]    load;
  } div_rsp_t;

endpackage

@@ rtl/smerm_if.sv @@
// Channel interfaces: input events, results and configuration writes.
interface smerm_in_if;
  logic                           valid;
  logic                           ready;
  logic [smerm_pkg::OP_W-1:0]     operation;
  logic                           cpu_busy;

  modport source (output valid, output operation, output cpu_busy, input ready);
  modport sink   (input valid, input operation, input cpu_busy, output ready);
endinterface

interface smerm_out_if;
  logic                            valid;
  logic                            ready;
  logic [smerm_pkg::SUM_W-1:0]     syscalls_per_minute;
  logic [smerm_pkg::SUM_W-1:0]     interrupts_per_minute;
  logic [smerm_pkg::SUM_W-1:0]     locks_per_minute;
  logic [smerm_pkg::LOAD_W-1:0]    load_percent;
  logic [smerm_pkg::TICK_W-1:0]    last_second_ticks;
  logic [smerm_pkg::TICK_W-1:0]    current_ticks;
  logic                            minute_wrapped;

  modport source (output valid, output syscalls_per_minute, output interrupts_per_minute,
                  output locks_per_minute, output load_percent, output last_second_ticks,
                  output current_ticks, output minute_wrapped, input ready);
  modport sink   (input valid, input syscalls_per_minute, input interrupts_per_minute,
                  input locks_per_minute, input load_percent, input last_second_ticks,
                  input current_ticks, input minute_wrapped, output ready);
endinterface

interface smerm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [smerm_pkg::CFG_IDX_W-1:0]    index;
  logic [smerm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/smerm_ring.sv @@
// Slot ring memory with per-row valid bits; unwritten rows read as zero.
module smerm_ring #(
  parameter int DEPTH = 60,
  parameter int ROW_W = 104
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ROW_W-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ROW_W-1:0]         wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ rtl/smerm_div.sv @@
// Restoring divider for load percent: busy*100 / (busy+idle), one quotient bit per cycle.
module smerm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smerm_pkg::div_req_t           req,
  input  logic [smerm_pkg::SUM_W-1:0]   busy_sum,
  input  logic [smerm_pkg::SUM_W-1:0]   idle_sum,
  output smerm_pkg::div_rsp_t           rsp
);

  logic [smerm_pkg::DIV_REM_W-1:0]  rem_r;
  logic [smerm_pkg::DIV_REM_W-1:0]  dvs_r;
  logic [smerm_pkg::LOAD_W-1:0]     q_r;
  logic [smerm_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                             run_r;
  logic                             done_r;
  logic                             zero_r;

  logic [smerm_pkg::SUM_W:0]        total_c;
  logic [smerm_pkg::DIV_REM_W-1:0]  busy_x;
  logic [smerm_pkg::DIV_REM_W-1:0]  num_c;
  logic                             ge_c;

  assign total_c = {1'b0, busy_sum} + {1'b0, idle_sum};
  assign busy_x  = smerm_pkg::DIV_REM_W'(busy_sum);
  // x100 = x64 + x32 + x4
  assign num_c   = (busy_x << 6) + (busy_x << 5) + (busy_x << 2);
  assign ge_c    = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= num_c;
      dvs_r  <= {1'b0, total_c, 6'b0};
      q_r    <= '0;
      zero_r <= (total_c == '0);
    end else if (run_r) begin
      if (ge_c) begin
        rem_r <= rem_r - dvs_r;
      end
      q_r   <= {q_r[smerm_pkg::LOAD_W-2:0], ge_c};
      dvs_r <= dvs_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= smerm_pkg::DIV_STEPS_LAST;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.load = zero_r ? '0 : ((q_r > smerm_pkg::PCT_MAX) ? smerm_pkg::PCT_MAX : q_r);

endmodule

@@ rtl/sliding_minute_event_rate_monitor_top.sv @@
// Top level of the sliding one-minute event rate monitor.
//
// Channels: in_ch carries one event per transfer (operation: tick, system call,
// interrupt or lock; cpu_busy on ticks). out_ch returns exactly one result per
// input transfer: window sums of the three event classes, busy load percent,
// last closed and open tick counts, and a minute-wrap flag. cfg_ch writes
// ticks_per_second (index 0) and monitor_enable (index 1); always ready;
// the user must write it only while no item is in flight; not enforced.
// Throughput: one item at a time. in_ch.ready is high only in idle. An item
// that does not close a second passes through the update state, the divider
// start and the 7-step restoring divider for the load percent before ready
// returns; one that closes a second also takes five extra passes of the single
// add/subtract unit that folds the new slot into the five window sums.
// Stall: the result sits in the out_ch register; a finished item waits in
// the sequencer until that register is free, and no input is taken meanwhile.
// Reset: rst_n (synchronous, active low) clears counters, sums, slot position
// and the ring valid bits, so every slot reads zero until first written;
// ticks_per_second returns to 1000 and monitoring is disabled.
module sliding_minute_event_rate_monitor_top #(
  parameter int WINDOW_SLOTS      = 60,
  parameter int EVENT_COUNT_WIDTH = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  smerm_in_if.sink       in_ch,
  smerm_out_if.source    out_ch,
  smerm_cfg_if.sink      cfg_ch
);

  localparam int EW    = EVENT_COUNT_WIDTH;
  localparam int TW    = smerm_pkg::TICK_W;
  localparam int SW    = smerm_pkg::SUM_W;
  localparam int PW    = $clog2(WINDOW_SLOTS);
  localparam int ROW_W = 3 * EW + 2 * TW;
  localparam logic [EW-1:0] EVT_MAX  = '1;
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_SLOTS - 1);

  // configuration
  logic [TW-1:0] tps_r;
  logic          en_r;

  // sequencer
  smerm_pkg::seq_state_t state_r, state_nxt;
  logic [smerm_pkg::SUM_IDX_W-1:0] k_r;

  // captured item
  smerm_pkg::op_t op_r;
  logic           busy_r;

  // open second and ring position
  logic [EW-1:0] open_sys_r, open_irq_r, open_lock_r;
  logic [TW-1:0] open_busy_r, open_idle_r, tick_r, closed_r;
  logic [PW-1:0] pos_r;
  logic          wrap_r;
  logic [SW-1:0] sums_r [smerm_pkg::SUM_COUNT];

  // result register
  logic                          out_valid_r;
  logic [SW-1:0]                 out_sys_r, out_irq_r, out_lock_r;
  logic [smerm_pkg::LOAD_W-1:0]  out_load_r;
  logic [TW-1:0]                 out_last_r, out_cur_r;
  logic                          out_wrap_r;

  // control strobes
  logic do_upd, do_rot, last_rot, load_out, out_free, close_c;
  logic [TW-1:0] tick_inc;

  smerm_pkg::div_req_t div_req;
  smerm_pkg::div_rsp_t div_rsp;

  logic [ROW_W-1:0] rd_row, wr_row;
  logic [SW-1:0]    fresh_c, old_c;

  // saturating tick increment and second close test
  assign tick_inc = (tick_r == smerm_pkg::TICK_MAX) ? tick_r : tick_r + 1'b1;
  assign close_c  = en_r && (op_r == smerm_pkg::OP_TICK) && (tick_inc >= tps_r);

  assign out_free = !out_valid_r || out_ch.ready;
  assign do_upd   = (state_r == smerm_pkg::S_UPD);
  assign do_rot   = (state_r == smerm_pkg::S_ROT);
  assign last_rot = do_rot && (k_r == smerm_pkg::SUM_IDLE);
  assign div_req.start = (state_r == smerm_pkg::S_DSTART);

  assign in_ch.ready  = (state_r == smerm_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smerm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and output load
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      smerm_pkg::S_IDLE: begin
        if (in_ch.valid) state_nxt = smerm_pkg::S_UPD;
      end
      smerm_pkg::S_UPD: begin
        state_nxt = close_c ? smerm_pkg::S_ROT : smerm_pkg::S_DSTART;
      end
      smerm_pkg::S_ROT: begin
        if (last_rot) state_nxt = smerm_pkg::S_DSTART;
      end
      smerm_pkg::S_DSTART: begin
        state_nxt = smerm_pkg::S_DIV;
      end
      smerm_pkg::S_DIV: begin
        if (div_rsp.done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = smerm_pkg::S_IDLE;
          end else begin
            state_nxt = smerm_pkg::S_OUT;
          end
        end
      end
      smerm_pkg::S_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = smerm_pkg::S_IDLE;
        end
      end
      default: state_nxt = smerm_pkg::S_IDLE;
    endcase
  end

  // ring row layout: sys | irq | lock | busy | idle
  assign wr_row = {open_sys_r, open_irq_r, open_lock_r, open_busy_r, open_idle_r};

  // operands of the shared sum update for sum k
  always_comb begin
    case (k_r)
      smerm_pkg::SUM_SYS: begin
        fresh_c = SW'(open_sys_r);
        old_c   = SW'(rd_row[ROW_W-1 -: EW]);
      end
      smerm_pkg::SUM_IRQ: begin
        fresh_c = SW'(open_irq_r);
        old_c   = SW'(rd_row[ROW_W-EW-1 -: EW]);
      end
      smerm_pkg::SUM_LOCK: begin
        fresh_c = SW'(open_lock_r);
        old_c   = SW'(rd_row[ROW_W-2*EW-1 -: EW]);
      end
      smerm_pkg::SUM_BUSY: begin
        fresh_c = SW'(open_busy_r);
        old_c   = SW'(rd_row[2*TW-1 -: TW]);
      end
      smerm_pkg::SUM_IDLE: begin
        fresh_c = SW'(open_idle_r);
        old_c   = SW'(rd_row[TW-1:0]);
      end
      default: begin
        fresh_c = '0;
        old_c   = '0;
      end
    endcase
  end

  smerm_ring #(
    .DEPTH (WINDOW_SLOTS),
    .ROW_W (ROW_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (do_upd),
    .rd_addr (pos_r),
    .rd_data (rd_row),
    .wr_en   (last_rot),
    .wr_addr (pos_r),
    .wr_data (wr_row)
  );

  smerm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy_sum (sums_r[smerm_pkg::SUM_BUSY]),
    .idle_sum (sums_r[smerm_pkg::SUM_IDLE]),
    .rsp      (div_rsp)
  );

  // captured item
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r   <= smerm_pkg::op_t'(in_ch.operation);
      busy_r <= in_ch.cpu_busy;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= smerm_pkg::TPS_RESET;
      en_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        smerm_pkg::CFG_TPS:    tps_r <= cfg_ch.data;
        smerm_pkg::CFG_ENABLE: en_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // counters, sums and ring position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_sys_r  <= '0;
      open_irq_r  <= '0;
      open_lock_r <= '0;
      open_busy_r <= '0;
      open_idle_r <= '0;
      tick_r      <= '0;
      closed_r    <= '0;
      pos_r       <= '0;
      wrap_r      <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < smerm_pkg::SUM_COUNT; i++) begin
        sums_r[i] <= '0;
      end
    end else if (do_upd) begin
      wrap_r <= 1'b0;
      k_r    <= '0;
      if (en_r) begin
        case (op_r)
          smerm_pkg::OP_TICK: begin
            tick_r <= tick_inc;
            if (busy_r) begin
              if (open_busy_r != smerm_pkg::TICK_MAX) open_busy_r <= open_busy_r + 1'b1;
            end else begin
              if (open_idle_r != smerm_pkg::TICK_MAX) open_idle_r <= open_idle_r + 1'b1;
            end
          end
          smerm_pkg::OP_SYSCALL: begin
            if (open_sys_r != EVT_MAX) open_sys_r <= open_sys_r + 1'b1;
          end
          smerm_pkg::OP_IRQ: begin
            if (open_irq_r != EVT_MAX) open_irq_r <= open_irq_r + 1'b1;
          end
          smerm_pkg::OP_LOCK: begin
            if (open_lock_r != EVT_MAX) open_lock_r <= open_lock_r + 1'b1;
          end
          default: ;
        endcase
      end
    end else if (do_rot) begin
      // one sum per cycle: add the closing second, drop the replaced slot
      sums_r[k_r] <= sums_r[k_r] + fresh_c - old_c;
      k_r         <= k_r + 1'b1;
      if (last_rot) begin
        open_sys_r  <= '0;
        open_irq_r  <= '0;
        open_lock_r <= '0;
        open_busy_r <= '0;
        open_idle_r <= '0;
        closed_r    <= tick_r;
        tick_r      <= '0;
        if (pos_r == POS_LAST) begin
          pos_r  <= '0;
          wrap_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sys_r  <= sums_r[smerm_pkg::SUM_SYS];
      out_irq_r  <= sums_r[smerm_pkg::SUM_IRQ];
      out_lock_r <= sums_r[smerm_pkg::SUM_LOCK];
      out_load_r <= div_rsp.load;
      out_last_r <= closed_r;
      out_cur_r  <= tick_r;
      out_wrap_r <= wrap_r;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.syscalls_per_minute   = out_sys_r;
  assign out_ch.interrupts_per_minute = out_irq_r;
  assign out_ch.locks_per_minute      = out_lock_r;
  assign out_ch.load_percent          = out_load_r;
  assign out_ch.last_second_ticks     = out_last_r;
  assign out_ch.current_ticks         = out_cur_r;
  assign out_ch.minute_wrapped        = out_wrap_r;

endmodule

@@ rtl/smerm_chk.sv @@
// Port-level checker for the monitor, bound to the top level.
module smerm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [smerm_pkg::SUM_W-1:0]     out_sys,
  input logic [smerm_pkg::LOAD_W-1:0]    out_load,
  input logic [smerm_pkg::TICK_W-1:0]    out_cur,
  input logic                            out_wrap
);

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_load <= smerm_pkg::PCT_MAX)
    else $error("load percent above 100");

  // a wrap only happens when a second closes, which clears the open count
  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrap |-> out_cur == '0)
    else $error("minute wrap with open ticks");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sys) && $stable(out_load))
    else $error("stalled result changed");

endmodule

bind sliding_minute_event_rate_monitor_top smerm_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sys   (out_ch.syscalls_per_minute),
  .out_load  (out_ch.load_percent),
  .out_cur   (out_ch.current_ticks),
  .out_wrap  (out_ch.minute_wrapped)
);
